FILE: hw/rtl/fpiq_pkg.sv
package fpiq_pkg;

  // Default number of key lanes
  localparam int unsigned NUM_KEYS_DEF = 5;

  // Configuration port geometry
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Register reset values
  localparam logic [7:0]  LOCK_TICKS_RST = 8'd10;
  localparam logic [7:0]  HOLD_STEP_RST  = 8'd10;
  localparam logic [15:0] HOLD_THR_RST   = 16'd1000;
  localparam logic [7:0]  BANK_MAX_RST   = 8'd99;

  // Register index (word address)
  typedef enum logic [2:0] {
    REG_KEY_LOCK  = 3'd0,
    REG_ENC_LOCK  = 3'd1,
    REG_BTN_LOCK  = 3'd2,
    REG_HOLD_STEP = 3'd3,
    REG_HOLD_THR  = 3'd4,
    REG_BANK_MAX  = 3'd5
  } reg_idx_t;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [7:0]  key_lock_ticks;
    logic [7:0]  encoder_lock_ticks;
    logic [7:0]  button_lock_ticks;
    logic [7:0]  hold_step;
    logic [15:0] hold_threshold;
    logic [7:0]  bank_max;
  } cfg_t;

endpackage

FILE: hw/rtl/fpiq_cfg.sv
module fpiq_cfg import fpiq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  // Word address; byte offset bits are ignored
  assign idx   = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KEY_LOCK:  cfg_nxt.key_lock_ticks     = pwdata[7:0];
        REG_ENC_LOCK:  cfg_nxt.encoder_lock_ticks = pwdata[7:0];
        REG_BTN_LOCK:  cfg_nxt.button_lock_ticks  = pwdata[7:0];
        REG_HOLD_STEP: cfg_nxt.hold_step          = pwdata[7:0];
        REG_HOLD_THR:  cfg_nxt.hold_threshold     = pwdata[15:0];
        REG_BANK_MAX:  cfg_nxt.bank_max           = pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_lock_ticks     <= LOCK_TICKS_RST;
      cfg_r.encoder_lock_ticks <= LOCK_TICKS_RST;
      cfg_r.button_lock_ticks  <= LOCK_TICKS_RST;
      cfg_r.hold_step          <= HOLD_STEP_RST;
      cfg_r.hold_threshold     <= HOLD_THR_RST;
      cfg_r.bank_max           <= BANK_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_KEY_LOCK:  prdata[7:0]  = cfg_r.key_lock_ticks;
      REG_ENC_LOCK:  prdata[7:0]  = cfg_r.encoder_lock_ticks;
      REG_BTN_LOCK:  prdata[7:0]  = cfg_r.button_lock_ticks;
      REG_HOLD_STEP: prdata[7:0]  = cfg_r.hold_step;
      REG_HOLD_THR:  prdata[15:0] = cfg_r.hold_threshold;
      REG_BANK_MAX:  prdata[7:0]  = cfg_r.bank_max;
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/front_panel_input_qualifier_core.sv
// Front panel input qualifier.
// Input channel (in_*): one tick sample per transfer with the key levels, encoder
// channels A/B and the encoder push button level. Result channel (out_*): one
// result per tick with per-key press pulses, the bank counter, a bank step flag
// and the long hold / short press flags of the push button.
// Config port: APB-style, register i at byte address 4*i, pready always high.
// Registers should only be written while no tick is in flight.
// A tick accepted into the sample register moves, by one pass of logic, into the
// result register that drives out_*; a result stall can hold it in between.
// Throughput: one tick per clock while out_stall is low; the result register and
// the sample register form a two-deep pipe, so a new tick is taken while a result
// waits. When out_stall is high the result holds; the sample register still fills,
// and in_stall rises once both stages are occupied.
// Reset (rst_n low, synchronous) empties the pipe, clears all debounce, lock,
// bank and hold state, and returns the registers to their default values.
module front_panel_input_qualifier_core import fpiq_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUM_KEYS-1:0] in_key_levels,
  input  logic                in_enc_a,
  input  logic                in_enc_b,
  input  logic                in_button_level,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NUM_KEYS-1:0] out_key_pressed,
  output logic [7:0]          out_bank_number,
  output logic                out_bank_changed,
  output logic                out_long_hold,
  output logic                out_short_press,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t cfg;

  fpiq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Pipe control
  // ---------------------------------------------------------------------------
  logic                s1_valid_r;
  logic [NUM_KEYS-1:0] s1_keys_r;
  logic                s1_a_r;
  logic                s1_b_r;
  logic                s1_btn_r;
  logic                out_valid_r;
  logic                out_take;
  logic                in_take;

  assign out_take  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~out_take;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (out_take) begin
        s1_valid_r <= 1'b0;
      end
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_keys_r <= in_key_levels;
      s1_a_r    <= in_enc_a;
      s1_b_r    <= in_enc_b;
      s1_btn_r  <= in_button_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Key lanes: falling edge detect with per-key lockout
  // ---------------------------------------------------------------------------
  logic [NUM_KEYS-1:0] key_prev_r;
  logic [7:0]          key_lock_r   [NUM_KEYS];
  logic [7:0]          key_lock_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0] key_pressed_nxt;

  always_comb begin
    logic [7:0] cnt;
    for (int i = 0; i < NUM_KEYS; i++) begin
      cnt = (key_lock_r[i] != 8'd0) ? key_lock_r[i] - 8'd1 : 8'd0;
      key_pressed_nxt[i] = key_prev_r[i] & ~s1_keys_r[i] & (cnt == 8'd0);
      key_lock_nxt[i]    = key_pressed_nxt[i] ? cfg.key_lock_ticks : cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_prev_r <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_lock_r[i] <= 8'd0;
      end
    end else if (out_take) begin
      key_prev_r <= s1_keys_r;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_lock_r[i] <= key_lock_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Encoder: channel A rising edge steps the bank, B gives direction
  // ---------------------------------------------------------------------------
  logic       enc_prev_a_r;
  logic [7:0] enc_lock_r;
  logic [7:0] enc_lock_nxt;
  logic [7:0] bank_r;
  logic [7:0] bank_nxt;
  logic       bank_changed_nxt;

  always_comb begin
    enc_lock_nxt     = enc_lock_r;
    bank_nxt         = bank_r;
    bank_changed_nxt = 1'b0;
    if (enc_lock_r != 8'd0) begin
      enc_lock_nxt = enc_lock_r - 8'd1;
    end else if (~enc_prev_a_r & s1_a_r) begin
      enc_lock_nxt     = cfg.encoder_lock_ticks;
      bank_changed_nxt = 1'b1;
      if (s1_b_r) begin
        bank_nxt = (bank_r != 8'd0) ? bank_r - 8'd1 : cfg.bank_max;
      end else begin
        bank_nxt = (bank_r < cfg.bank_max) ? bank_r + 8'd1 : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_prev_a_r <= 1'b0;
      enc_lock_r   <= 8'd0;
      bank_r       <= 8'd0;
    end else if (out_take) begin
      enc_prev_a_r <= s1_a_r;
      enc_lock_r   <= enc_lock_nxt;
      bank_r       <= bank_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Push button: short press / long hold qualification
  // ---------------------------------------------------------------------------
  logic        btn_prev_r;
  logic        btn_prev_nxt;
  logic        btn_armed_r;
  logic        btn_armed_nxt;
  logic [7:0]  btn_lock_r;
  logic [7:0]  btn_lock_nxt;
  logic [15:0] held_r;
  logic [15:0] held_nxt;
  logic [16:0] held_sum;
  logic [15:0] held_sat;
  logic        btn_rise;
  logic        btn_hold;
  logic        btn_rel;
  logic        long_hold_nxt;
  logic        short_press_nxt;

  assign held_sum = {1'b0, held_r} + {9'd0, cfg.hold_step};
  assign held_sat = held_sum[16] ? 16'hFFFF : held_sum[15:0];
  assign btn_rise = ~btn_prev_r & s1_btn_r;
  assign btn_hold = btn_prev_r & s1_btn_r & btn_armed_r;
  assign btn_rel  = ~btn_prev_r & ~s1_btn_r & btn_armed_r;

  always_comb begin
    btn_prev_nxt    = btn_prev_r;
    btn_armed_nxt   = btn_armed_r;
    btn_lock_nxt    = btn_lock_r;
    held_nxt        = held_r;
    long_hold_nxt   = 1'b0;
    short_press_nxt = 1'b0;
    if (btn_lock_r != 8'd0) begin
      btn_lock_nxt = btn_lock_r - 8'd1;
    end else begin
      btn_prev_nxt = s1_btn_r;
      if (btn_rise) begin
        btn_armed_nxt = 1'b1;
        btn_lock_nxt  = cfg.button_lock_ticks;
        held_nxt      = 16'd0;
      end
      if (btn_hold) begin
        held_nxt     = held_sat;
        btn_lock_nxt = cfg.button_lock_ticks;
        if (held_sat >= cfg.hold_threshold) begin
          long_hold_nxt = 1'b1;
          btn_armed_nxt = 1'b0;
        end
      end
      if (btn_rel) begin
        btn_armed_nxt   = 1'b0;
        short_press_nxt = (held_r < cfg.hold_threshold);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_prev_r  <= 1'b0;
      btn_armed_r <= 1'b0;
      btn_lock_r  <= 8'd0;
      held_r      <= 16'd0;
    end else if (out_take) begin
      btn_prev_r  <= btn_prev_nxt;
      btn_armed_r <= btn_armed_nxt;
      btn_lock_r  <= btn_lock_nxt;
      held_r      <= held_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [NUM_KEYS-1:0] out_key_pressed_r;
  logic [7:0]          out_bank_number_r;
  logic                out_bank_changed_r;
  logic                out_long_hold_r;
  logic                out_short_press_r;

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_key_pressed_r  <= key_pressed_nxt;
      out_bank_number_r  <= bank_nxt;
      out_bank_changed_r <= bank_changed_nxt;
      out_long_hold_r    <= long_hold_nxt;
      out_short_press_r  <= short_press_nxt;
    end
  end

  assign out_key_pressed  = out_key_pressed_r;
  assign out_bank_number  = out_bank_number_r;
  assign out_bank_changed = out_bank_changed_r;
  assign out_long_hold    = out_long_hold_r;
  assign out_short_press  = out_short_press_r;

`ifndef ASSERT_OFF
  // Long hold and short press are exclusive outcomes of one evaluation
  a_btn_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_long_hold_r && out_short_press_r))
    else $error("long hold and short press reported together");

  // Arming the button always starts from a cleared held time
  a_arm_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(btn_armed_r) |-> (held_r == 16'd0))
    else $error("button armed with stale held time");

  // A sampled tick is never dropped while the result side is blocked
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_take) |=> s1_valid_r)
    else $error("pending tick lost");
`endif

endmodule
